@@ hw/rtl/cosine_arch_distance_filter_top_defines.svh @@
// Assertion helpers used by the checker file
`ifndef COSINE_ARCH_DISTANCE_FILTER_TOP_DEFINES_SVH
`define COSINE_ARCH_DISTANCE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define CADF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define CADF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cadf_pkg.sv @@
`timescale 1ns / 1ps
package cadf_pkg;

    localparam int D_W = 32;
    localparam int W_W = 17;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Configuration register indexes
    localparam logic CFG_FILTER_WIDTH   = 1'b0;
    localparam logic CFG_ACTIVE_COLUMNS = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // Store read address selects
    localparam logic [1:0] RD_FETCH  = 2'd0;
    localparam logic [1:0] RD_WSTART = 2'd1;
    localparam logic [1:0] RD_WSTOP  = 2'd2;
    localparam logic [1:0] RD_ITER   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       emit_bad;
        logic       cap_own;
        logic [1:0] rd_sel;
        logic       ws_inc;
        logic       wstop_inc;
        logic       it_init;
        logic       it_inc;
        logic       ad_cap;
        logic       kdiv_init;
        logic       kdiv_step;
        logic       mac1;
        logic       mac2;
        logic       div_start;
        logic       div_col;
        logic       div_cap;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic aw_zero;
        logic ws_lt_pc;
        logic wstop_lt_pc;
        logic start_adv;
        logic stop_adv;
        logic it_lt_stop;
        logic k_ok;
        logic kdiv_last;
        logic den_zero;
        logic two_col;
        logic fetch_bad;
        logic div_done;
    } t_sts;

    // Arch weight for a Q30 angle; evaluated at elaboration only
    function automatic logic [W_W-1:0] cos_weight(input logic [63:0] y,
                                                  input logic first_half);
        logic [63:0] y2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] s;
        y2 = (y * y + (ONE_Q30 >> 1)) >> 30;
        t  = ONE_Q30;
        for (int n = 0; n < 6; n++) begin
            p = (y2 * t) >> 30;
            case (n)
                0:       q = p / 64'd132;
                1:       q = p / 64'd90;
                2:       q = p / 64'd56;
                3:       q = p / 64'd30;
                4:       q = p / 64'd12;
                default: q = p / 64'd2;
            endcase
            t = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
        end
        s = first_half ? (ONE_Q30 + t + 64'd16384) : (ONE_Q30 - t + 64'd16384);
        return s[15+W_W-1:15];
    endfunction

endpackage

@@ hw/rtl/cadf_div.sv @@
`timescale 1ns / 1ps
module cadf_div #(
    parameter int NUM_W = 65,
    parameter int DEN_W = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DEN_W:0]   w_t;
    logic             w_ge;

    // Trial subtract of one quotient bit
    assign w_t  = {r_rem, r_quo[NUM_W-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    // Control: count steps, flag the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring shift-subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : w_t[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ hw/rtl/cadf_dp.sv @@
`timescale 1ns / 1ps
module cadf_dp #(
    parameter int MAX_POINTS = 1024,
    parameter int TABLE_SIZE = 1000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cadf_pkg::t_cmd      i_cmd,
    output cadf_pkg::t_sts      o_sts,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic [31:0]         i_distance,
    input  logic signed [31:0]  i_value_a,
    input  logic signed [31:0]  i_value_b,
    input  logic                i_last,
    output logic signed [31:0]  o_out_a,
    output logic signed [31:0]  o_out_b,
    output logic                o_out_last,
    output logic [1:0]          o_status
);
    import cadf_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int PW    = AW + 1;
    localparam int QB    = $clog2(TABLE_SIZE);
    localparam int NK_W  = 32 + QB;
    localparam int KC_W  = $clog2(QB + 1);
    localparam int DEN_W = W_W + PW;
    localparam int NUM_W = 65;
    localparam int P_W   = D_W + W_W + 1;

    // Weight table built at elaboration
    logic [W_W-1:0] w_rom [TABLE_SIZE];
    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        localparam bit FH = (2 * g <= TABLE_SIZE);
        localparam logic [63:0] M = FH ? 64'(g) : 64'(TABLE_SIZE - g);
        localparam logic [63:0] Y = (PI_Q30 * M + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
        localparam logic [W_W-1:0] WV = cos_weight(Y, FH);
        assign w_rom[g] = WV;
    end

    // Point stores
    logic [31:0] r_mem_d [MAX_POINTS];
    logic [31:0] r_mem_a [MAX_POINTS];
    logic [31:0] r_mem_b [MAX_POINTS];

    // Control state
    logic signed [31:0] r_fw;
    logic [1:0]         r_cols;
    logic [PW-1:0]      r_pc, r_fi, r_ws, r_wst, r_it;
    logic               r_closed, r_ovf;
    logic [KC_W-1:0]    r_kcnt;

    // Payload registers
    logic [31:0]        r_rd_d;
    logic signed [31:0] r_rd_a, r_rd_b;
    logic [31:0]        r_dj;
    logic signed [31:0] r_own_a, r_own_b;
    logic [31:0]        r_ad;
    logic signed [31:0] r_va, r_vb;
    logic [31:0]        r_kr;
    logic [QB-1:0]      r_kq;
    logic [W_W-1:0]     r_w;
    logic signed [P_W-1:0] r_pa, r_pb;
    logic [63:0]        r_acc_a, r_acc_b;
    logic [DEN_W-1:0]   r_den;
    logic               r_div_col, r_neg;
    logic signed [65:0] r_sm_a, r_sm_b;
    logic signed [31:0] r_out_a, r_out_b;
    logic               r_out_last;
    logic [1:0]         r_status;

    logic [31:0]        w_aw;
    logic [PW-1:0]      w_pc_eff;
    logic               w_we;
    logic [PW-1:0]      w_rsel;
    logic [AW-1:0]      w_raddr;
    logic signed [34:0] w_diff, w_dbl, w_awx;
    logic [NK_W-1:0]    w_knum;
    logic [32:0]        w_kt;
    logic               w_kge;
    logic [63:0]        w_acc_sel, w_mag;
    logic [NUM_W-1:0]   w_num;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic signed [65:0] w_sm, w_sa, w_sb;
    logic signed [31:0] w_res_a, w_res_b;
    logic               w_hp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign w_aw     = r_fw[31] ? 32'(-r_fw) : r_fw;
    assign w_hp     = r_fw[31];
    assign w_pc_eff = r_closed ? '0 : r_pc;
    assign w_we     = i_cmd.load && (w_pc_eff < PW'(MAX_POINTS));

    // Select the store read address
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FETCH:  w_rsel = r_fi;
            RD_WSTART: w_rsel = r_ws;
            RD_WSTOP:  w_rsel = r_wst;
            RD_ITER:   w_rsel = r_it;
        endcase
    end
    assign w_raddr = w_rsel[AW-1:0];

    // Window and distance arithmetic
    assign w_diff = $signed({3'b000, r_rd_d}) - $signed({3'b000, r_dj});
    assign w_dbl  = w_diff <<< 1;
    assign w_awx  = $signed({3'b000, w_aw});
    assign w_knum = NK_W'(r_ad[30:0]) * NK_W'(2 * TABLE_SIZE);
    assign w_kt   = {r_kr, r_kq[QB-1]};
    assign w_kge  = w_kt >= {1'b0, w_aw};

    // Rounded divide operand: magnitude plus half the divisor
    assign w_acc_sel = i_cmd.div_col ? r_acc_b : r_acc_a;
    assign w_mag     = w_acc_sel[63] ? 64'(-w_acc_sel) : w_acc_sel;
    assign w_num     = {1'b0, w_mag} + NUM_W'(r_den >> 1);
    assign w_sm      = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    cadf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Final values per column
    assign w_sa    = (r_den == '0) ? 66'(r_own_a) : r_sm_a;
    assign w_sb    = (r_den == '0) ? 66'(r_own_b) : r_sm_b;
    assign w_res_a = w_hp ? sat32(66'(r_own_a) - w_sa) : w_sa[31:0];
    assign w_res_b = w_hp ? sat32(66'(r_own_b) - w_sb) : w_sb[31:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= '0;
            r_cols   <= 2'd1;
            r_pc     <= '0;
            r_fi     <= '0;
            r_ws     <= '0;
            r_wst    <= '0;
            r_it     <= '0;
            r_closed <= 1'b0;
            r_ovf    <= 1'b0;
            r_kcnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FILTER_WIDTH) begin
                    r_fw <= i_cfg_data;
                end else begin
                    r_cols <= i_cfg_data[1:0];
                end
            end
            if (i_cmd.load) begin
                if (r_closed) begin
                    r_fi  <= '0;
                    r_ws  <= '0;
                    r_wst <= '0;
                    r_ovf <= 1'b0;
                end
                if (w_we) begin
                    r_pc <= w_pc_eff + 1'b1;
                end else begin
                    r_pc  <= w_pc_eff;
                    r_ovf <= 1'b1;
                end
                r_closed <= i_last;
            end
            if (i_cmd.ws_inc)    r_ws  <= r_ws + 1'b1;
            if (i_cmd.wstop_inc) r_wst <= r_wst + 1'b1;
            if (i_cmd.it_init) begin
                r_it <= r_ws;
            end else if (i_cmd.it_inc) begin
                r_it <= r_it + 1'b1;
            end
            if (i_cmd.kdiv_init) begin
                r_kcnt <= KC_W'(QB);
            end else if (i_cmd.kdiv_step) begin
                r_kcnt <= r_kcnt - 1'b1;
            end
            if (i_cmd.fin) r_fi <= r_fi + 1'b1;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_d[w_pc_eff[AW-1:0]] <= i_distance;
            r_mem_a[w_pc_eff[AW-1:0]] <= i_value_a;
            r_mem_b[w_pc_eff[AW-1:0]] <= i_value_b;
        end
        r_rd_d <= r_mem_d[w_raddr];
        r_rd_a <= r_mem_a[w_raddr];
        r_rd_b <= r_mem_b[w_raddr];
    end

    // Filter datapath
    always_ff @(posedge i_clk) begin
        r_w <= w_rom[r_kq];
        if (i_cmd.cap_own) begin
            r_dj    <= r_rd_d;
            r_own_a <= r_rd_a;
            r_own_b <= r_rd_b;
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_den   <= '0;
        end
        if (i_cmd.ad_cap) begin
            r_ad <= w_diff[34] ? 32'(-w_diff) : w_diff[31:0];
            r_va <= r_rd_a;
            r_vb <= r_rd_b;
        end
        if (i_cmd.kdiv_init) begin
            r_kr <= w_knum[NK_W-1:QB];
            r_kq <= w_knum[QB-1:0];
        end else if (i_cmd.kdiv_step) begin
            r_kr <= w_kge ? 32'(w_kt - {1'b0, w_aw}) : w_kt[31:0];
            r_kq <= {r_kq[QB-2:0], w_kge};
        end
        if (i_cmd.mac1) begin
            r_pa <= P_W'(r_va * $signed({1'b0, r_w}));
            r_pb <= P_W'(r_vb * $signed({1'b0, r_w}));
        end
        if (i_cmd.mac2) begin
            r_acc_a <= r_acc_a + 64'(r_pa);
            r_acc_b <= r_acc_b + 64'(r_pb);
            r_den   <= r_den + DEN_W'(r_w);
        end
        if (i_cmd.div_start) begin
            r_div_col <= i_cmd.div_col;
            r_neg     <= w_acc_sel[63];
        end
        if (i_cmd.div_cap) begin
            if (r_div_col) r_sm_b <= w_sm;
            else           r_sm_a <= w_sm;
        end
        if (i_cmd.emit_bad) begin
            r_out_a    <= '0;
            r_out_b    <= '0;
            r_out_last <= 1'b0;
            r_status   <= ST_EMPTY;
        end else if (i_cmd.fin) begin
            r_out_a    <= w_res_a;
            r_out_b    <= r_cols[1] ? w_res_b : 32'sd0;
            r_out_last <= (r_fi + 1'b1) == r_pc;
            r_status   <= r_ovf ? ST_DROPPED : ST_OK;
        end
    end

    // Status toward the controller
    assign o_sts.aw_zero     = (w_aw == '0);
    assign o_sts.ws_lt_pc    = r_ws < r_pc;
    assign o_sts.wstop_lt_pc = r_wst < r_pc;
    assign o_sts.start_adv   = w_dbl <= -w_awx;
    assign o_sts.stop_adv    = w_dbl < w_awx;
    assign o_sts.it_lt_stop  = r_it < r_wst;
    assign o_sts.k_ok        = {r_ad, 1'b0} < {1'b0, w_aw};
    assign o_sts.kdiv_last   = r_kcnt == KC_W'(1);
    assign o_sts.den_zero    = r_den == '0;
    assign o_sts.two_col     = r_cols[1];
    assign o_sts.fetch_bad   = !r_closed || (r_fi >= r_pc);
    assign o_sts.div_done    = w_div_done;

    assign o_out_a    = r_out_a;
    assign o_out_b    = r_out_b;
    assign o_out_last = r_out_last;
    assign o_status   = r_status;
endmodule

@@ hw/rtl/cadf_ctrl.sv @@
`timescale 1ns / 1ps
module cadf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_mode,
    output logic           busy,
    output logic           o_strobe,
    output cadf_pkg::t_cmd o_cmd,
    input  cadf_pkg::t_sts i_sts
);
    import cadf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_OWN    = 5'd1;
    localparam logic [4:0] S_ST_RD  = 5'd2;
    localparam logic [4:0] S_ST_CK  = 5'd3;
    localparam logic [4:0] S_SP_RD  = 5'd4;
    localparam logic [4:0] S_SP_CK  = 5'd5;
    localparam logic [4:0] S_PT_RD  = 5'd6;
    localparam logic [4:0] S_PT_CK  = 5'd7;
    localparam logic [4:0] S_PT_MUL = 5'd8;
    localparam logic [4:0] S_KDIV   = 5'd9;
    localparam logic [4:0] S_WRD    = 5'd10;
    localparam logic [4:0] S_MAC1   = 5'd11;
    localparam logic [4:0] S_MAC2   = 5'd12;
    localparam logic [4:0] S_DIV_A  = 5'd13;
    localparam logic [4:0] S_WAIT_A = 5'd14;
    localparam logic [4:0] S_DIV_B  = 5'd15;
    localparam logic [4:0] S_WAIT_B = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_strobe, n_strobe;
    t_cmd       w_cmd;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        w_cmd        = '0;
        w_cmd.rd_sel = RD_FETCH;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_mode) begin
                        w_cmd.load = 1'b1;
                    end else if (i_sts.fetch_bad) begin
                        w_cmd.emit_bad = 1'b1;
                    end else begin
                        n_state = S_OWN;
                    end
                end
            end
            S_OWN: begin
                w_cmd.cap_own = 1'b1;
                n_state = i_sts.aw_zero ? S_FIN : S_ST_RD;
            end
            S_ST_RD: begin
                w_cmd.rd_sel = RD_WSTART;
                n_state = i_sts.ws_lt_pc ? S_ST_CK : S_SP_RD;
            end
            S_ST_CK: begin
                if (i_sts.start_adv) begin
                    w_cmd.ws_inc = 1'b1;
                    n_state = S_ST_RD;
                end else begin
                    n_state = S_SP_RD;
                end
            end
            S_SP_RD: begin
                w_cmd.rd_sel = RD_WSTOP;
                if (i_sts.wstop_lt_pc) begin
                    n_state = S_SP_CK;
                end else begin
                    w_cmd.it_init = 1'b1;
                    n_state = S_PT_RD;
                end
            end
            S_SP_CK: begin
                if (i_sts.stop_adv) begin
                    w_cmd.wstop_inc = 1'b1;
                    n_state = S_SP_RD;
                end else begin
                    w_cmd.it_init = 1'b1;
                    n_state = S_PT_RD;
                end
            end
            S_PT_RD: begin
                w_cmd.rd_sel = RD_ITER;
                n_state = i_sts.it_lt_stop ? S_PT_CK : S_DIV_A;
            end
            S_PT_CK: begin
                w_cmd.ad_cap = 1'b1;
                n_state = S_PT_MUL;
            end
            S_PT_MUL: begin
                if (i_sts.k_ok) begin
                    w_cmd.kdiv_init = 1'b1;
                    n_state = S_KDIV;
                end else begin
                    w_cmd.it_inc = 1'b1;
                    n_state = S_PT_RD;
                end
            end
            S_KDIV: begin
                w_cmd.kdiv_step = 1'b1;
                if (i_sts.kdiv_last) n_state = S_WRD;
            end
            S_WRD: begin
                n_state = S_MAC1;
            end
            S_MAC1: begin
                w_cmd.mac1 = 1'b1;
                n_state = S_MAC2;
            end
            S_MAC2: begin
                w_cmd.mac2   = 1'b1;
                w_cmd.it_inc = 1'b1;
                n_state = S_PT_RD;
            end
            S_DIV_A: begin
                if (i_sts.den_zero) begin
                    n_state = S_FIN;
                end else begin
                    w_cmd.div_start = 1'b1;
                    n_state = S_WAIT_A;
                end
            end
            S_WAIT_A: begin
                if (i_sts.div_done) begin
                    w_cmd.div_cap = 1'b1;
                    n_state = i_sts.two_col ? S_DIV_B : S_FIN;
                end
            end
            S_DIV_B: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_col   = 1'b1;
                n_state = S_WAIT_B;
            end
            S_WAIT_B: begin
                if (i_sts.div_done) begin
                    w_cmd.div_cap = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_strobe = w_cmd.emit_bad | w_cmd.fin;
    end

    // Hold state and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_cmd    = w_cmd;
endmodule

@@ hw/rtl/cosine_arch_distance_filter_top.sv @@
`timescale 1ns / 1ps
// Load: one point per cycle while not busy, no result. Fetch without a segment: strobe in the
// next cycle. Fetch: time grows with window moves, weighted and skipped neighbors and filtered
// columns, set by the single store read port, the bit-serial index divider and the 65-step
// rounding divider; with a zero filter width the fetch skips the window and neighbor work.
// Synchronous active-low reset initializes pointers, flags and control state; stores and payload are not cleared.
// The receiver cannot stall: each result transfer lasts one cycle.
module cosine_arch_distance_filter_top #(
    parameter int MAX_POINTS = 1024,
    parameter int TABLE_SIZE = 1000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [31:0]        i_distance,
    input  logic signed [31:0] i_value_a,
    input  logic signed [31:0] i_value_b,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [31:0] o_out_a,
    output logic signed [31:0] o_out_b,
    output logic               o_out_last,
    output logic [1:0]         o_status
);
    import cadf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cadf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd),
        .i_sts    (w_sts)
    );

    cadf_dp #(
        .MAX_POINTS (MAX_POINTS),
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_distance (i_distance),
        .i_value_a  (i_value_a),
        .i_value_b  (i_value_b),
        .i_last     (i_last),
        .o_out_a    (o_out_a),
        .o_out_b    (o_out_b),
        .o_out_last (o_out_last),
        .o_status   (o_status)
    );
endmodule

@@ hw/rtl/cadf_chk.sv @@
`timescale 1ns / 1ps
`include "cosine_arch_distance_filter_top_defines.svh"
module cadf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_mode,
    input logic        o_strobe,
    input logic [31:0] o_out_a,
    input logic [31:0] o_out_b,
    input logic        o_out_last,
    input logic [1:0]  o_status
);
    import cadf_pkg::*;

    // A load transfer never causes a result
    `CADF_ASSERT_NEXT(a_load_quiet, start && !busy && !i_mode, !o_strobe, "result after load")
    // An empty fetch result carries zero payload
    `CADF_ASSERT_NOW(a_empty_zero, o_strobe && o_status == ST_EMPTY, o_out_a == 32'd0 && o_out_b == 32'd0 && !o_out_last, "empty result not zero")
    // Busy only starts from an accepted fetch
    `CADF_ASSERT_NOW(a_busy_src, $rose(busy), $past(start && i_mode), "busy without fetch")
    // A result ends the work on its item
    `CADF_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result while busy")
endmodule

bind cosine_arch_distance_filter_top cadf_chk u_cadf_chk (.*);
